@@ hw/rtl/four_way_hash_table_depth_age_replace_macros.svh @@
// assertion macros for the four-way hash table
`ifndef FOUR_WAY_HASH_TABLE_DEPTH_AGE_REPLACE_MACROS_SVH
`define FOUR_WAY_HASH_TABLE_DEPTH_AGE_REPLACE_MACROS_SVH
`ifndef SYNTH
// check that is masked while reset is low
`define FWHT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds around reset
`define FWHT_ASSERT_ON(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FWHT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FWHT_ASSERT_ON(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/fwht_pkg.sv @@
// types, constants and codes shared by the four-way hash table modules
package fwht_pkg;

    // table geometry
    localparam int IDX_MAX   = 10;
    localparam int WAYS      = 4;
    localparam int ADDR_W    = (IDX_MAX > 0) ? IDX_MAX : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_EFF_W = 5;

    // configuration port
    localparam int CFG_W      = 8;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BITS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GENERATION = 1'd1;

    // replacement score: depth*16 - age*2 + (move != 0), biased to stay non-negative
    localparam int AGE_W      = 3;
    localparam int SCORE_W    = 11;
    localparam int STALE_BIAS = 7 * 2;

    // command codes
    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_PUT   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // outcome codes
    localparam logic [2:0] OUT_MISS     = 3'd0;
    localparam logic [2:0] OUT_HIT      = 3'd1;
    localparam logic [2:0] OUT_UPDATED  = 3'd2;
    localparam logic [2:0] OUT_FILLED   = 3'd3;
    localparam logic [2:0] OUT_REPLACED = 3'd4;
    localparam logic [2:0] OUT_CLEARED  = 3'd5;

    typedef struct packed {
        logic [1:0]         command;
        logic [63:0]        key;
        logic [6:0]         search_depth;
        logic [15:0]        best_move;
        logic signed [15:0] score_value;
        logic               value_given;
        logic [1:0]         bound_type;
        logic signed [15:0] static_eval;
        logic               eval_given;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         outcome;
        logic [6:0]         hit_depth;
        logic [15:0]        hit_move;
        logic signed [15:0] hit_value;
        logic [1:0]         hit_type;
        logic signed [15:0] hit_eval;
        logic [7:0]         hit_generation;
    } t_result;

    // one way of a cluster as stored
    typedef struct packed {
        logic               valid;
        logic [63:0]        tag;
        logic [6:0]         depth;
        logic [15:0]        move;
        logic signed [15:0] value;
        logic [1:0]         btype;
        logic [7:0]         gen;
        logic signed [15:0] eval;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // verdict of the shared way unit
    typedef struct packed {
        logic               hit;
        logic               empty;
        logic [SCORE_W-1:0] score;
    } t_way_eval;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_WRITE,
        S_CLEAR
    } t_state;

endpackage

@@ hw/rtl/fwht_ram.sv @@
// single-port-write, single-port-read cluster memory with registered read data
module fwht_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [(1 << ADDR_W)];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/fwht_way_unit.sv @@
// shared per-way unit: tag match, empty test and replacement score
module fwht_way_unit (
    input  fwht_pkg::t_entry    i_entry,
    input  logic [63:0]         i_key,
    input  logic [7:0]          i_gen,
    output fwht_pkg::t_way_eval o_eval
);

    logic [fwht_pkg::AGE_W-1:0] w_age;
    logic                       w_move_nz;

    // age modulo 8 against the current generation
    assign w_age     = i_gen[fwht_pkg::AGE_W-1:0] - i_entry.gen[fwht_pkg::AGE_W-1:0];
    assign w_move_nz = (i_entry.move != 16'd0);

    // verdict for one way; biased score keeps the value unsigned with the same ordering
    always_comb begin
        o_eval.hit   = i_entry.valid && (i_entry.tag == i_key);
        o_eval.empty = !i_entry.valid;
        o_eval.score = fwht_pkg::SCORE_W'({i_entry.depth, 4'b0000})
                     + fwht_pkg::SCORE_W'(fwht_pkg::STALE_BIAS)
                     - fwht_pkg::SCORE_W'({w_age, 1'b0})
                     + fwht_pkg::SCORE_W'(w_move_nz);
    end

endmodule

@@ hw/rtl/four_way_hash_table_depth_age_replace.sv @@
// four-way set-associative search-result table with depth/age replacement
//
// Usage: a transaction is taken at a clock edge where start is high and busy
// is low; i_cmd carries probe, put or clear. Each transaction returns one
// result on o_result, marked by o_done for exactly one cycle; the receiver
// cannot hold it off. busy is low again in the cycle that shows o_done.
// Sequence after the accepting edge:
//   probe and put: the cluster row is read, then one shared compare/score
//   unit looks at one way of the fetched cluster per cycle, stopping at the
//   tag hit or after the last way; a put then writes the row back to the
//   cluster memory.
//   clear: one cluster row per cycle over all 1024 rows, then o_done.
//   unused command: the accepting edge itself raises o_done, nothing changes.
// A new transaction is taken only once the last one is done. Configuration
// writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) land at once; the user must
// make them while idle, which the block itself does not enforce: index 0 is
// index_bits, index 1 is generation. After reset the block walks all 1024
// cluster rows to empty them, holding busy high until the walk ends;
// index_bits returns to 10 and generation to 0.
`include "four_way_hash_table_depth_age_replace_macros.svh"

module four_way_hash_table_depth_age_replace (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  fwht_pkg::t_cmd                    i_cmd,
    output logic                              busy,
    output logic                              o_done,
    output fwht_pkg::t_result                 o_result,
    input  logic                              i_cfg_we,
    input  logic [fwht_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [fwht_pkg::CFG_W-1:0]        i_cfg_wdata
);

    fwht_pkg::t_state                 r_state, n_state;
    fwht_pkg::t_cmd                   r_in, n_in;
    logic [fwht_pkg::ADDR_W-1:0]      r_addr, n_addr;
    logic [fwht_pkg::WAY_W-1:0]       r_way, n_way;
    logic [fwht_pkg::WAY_W-1:0]       r_sel_way, n_sel_way;
    logic [2:0]                       r_wr_outcome, n_wr_outcome;
    logic                             r_empty_found, n_empty_found;
    logic [fwht_pkg::WAY_W-1:0]       r_empty_way, n_empty_way;
    logic                             r_victim_found, n_victim_found;
    logic [fwht_pkg::WAY_W-1:0]       r_victim_way, n_victim_way;
    logic [fwht_pkg::SCORE_W-1:0]     r_vscore, n_vscore;
    logic [fwht_pkg::ADDR_W-1:0]      r_clr_addr, n_clr_addr;
    logic                             r_clr_cmd, n_clr_cmd;
    logic [3:0]                       r_idx_bits, n_idx_bits;
    logic [7:0]                       r_gen, n_gen;
    logic                             r_done, n_done;
    fwht_pkg::t_result                r_result, n_result;

    logic                             w_accept;
    logic [fwht_pkg::IDX_EFF_W-1:0]   w_idx_eff;
    logic [fwht_pkg::ADDR_W-1:0]      w_mask;
    logic                             w_rd_en;
    logic                             w_wr_en;
    logic [fwht_pkg::ADDR_W-1:0]      w_wr_addr;
    fwht_pkg::t_row                   w_row;
    fwht_pkg::t_row                   w_wr_row;
    fwht_pkg::t_entry                 w_cur;
    fwht_pkg::t_entry                 w_sel;
    fwht_pkg::t_entry                 w_new;
    fwht_pkg::t_way_eval              w_eval;
    logic                             w_miss_shown;
    logic                             w_fields_zero;

    assign w_accept = start && !busy;
    assign busy     = (r_state != fwht_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // cluster index from the low key bits, index_bits saturated
    assign w_idx_eff = (r_idx_bits > fwht_pkg::IDX_MAX)
                     ? fwht_pkg::IDX_EFF_W'(fwht_pkg::IDX_MAX)
                     : fwht_pkg::IDX_EFF_W'(r_idx_bits);
    assign w_mask    = ~({fwht_pkg::ADDR_W{1'b1}} << w_idx_eff);

    // cluster memory
    fwht_ram #(
        .WIDTH  (fwht_pkg::ROW_W),
        .ADDR_W (fwht_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_row),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_row)
    );

    // shared way unit, one way per scan cycle
    assign w_cur = w_row[r_way];
    assign w_sel = w_row[r_sel_way];

    fwht_way_unit u_way (
        .i_entry (w_cur),
        .i_key   (r_in.key),
        .i_gen   (r_gen),
        .o_eval  (w_eval)
    );

    // entry written back by a put
    always_comb begin
        w_new       = '0;
        w_new.valid = 1'b1;
        if (r_wr_outcome == fwht_pkg::OUT_UPDATED) begin
            w_new       = w_sel;
            w_new.valid = 1'b1;
            if (r_in.best_move != 16'd0) begin
                w_new.move = r_in.best_move;
            end
            if (r_in.value_given) begin
                w_new.depth = r_in.search_depth;
                w_new.value = r_in.score_value;
                w_new.btype = r_in.bound_type;
                w_new.gen   = r_gen;
            end
            if (r_in.eval_given) begin
                w_new.eval = r_in.static_eval;
            end
        end else begin
            w_new.tag   = r_in.key;
            w_new.depth = r_in.search_depth;
            w_new.move  = r_in.best_move;
            w_new.value = r_in.score_value;
            w_new.btype = r_in.bound_type;
            w_new.gen   = r_gen;
            w_new.eval  = r_in.static_eval;
        end
    end

    // sequencer: next state and outputs
    always_comb begin
        logic                         se_found;
        logic [fwht_pkg::WAY_W-1:0]   se_way;
        logic                         sv_found;
        logic [fwht_pkg::WAY_W-1:0]   sv_way;
        logic [fwht_pkg::SCORE_W-1:0] sv_score;

        n_state        = r_state;
        n_in           = r_in;
        n_addr         = r_addr;
        n_way          = r_way;
        n_sel_way      = r_sel_way;
        n_wr_outcome   = r_wr_outcome;
        n_empty_found  = r_empty_found;
        n_empty_way    = r_empty_way;
        n_victim_found = r_victim_found;
        n_victim_way   = r_victim_way;
        n_vscore       = r_vscore;
        n_clr_addr     = r_clr_addr;
        n_clr_cmd      = r_clr_cmd;
        n_idx_bits     = r_idx_bits;
        n_gen          = r_gen;
        n_done         = 1'b0;
        n_result       = r_result;
        w_rd_en        = 1'b0;
        w_wr_en        = 1'b0;
        w_wr_addr      = r_addr;
        w_wr_row       = w_row;

        se_found = r_empty_found;
        se_way   = r_empty_way;
        sv_found = r_victim_found;
        sv_way   = r_victim_way;
        sv_score = r_vscore;

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_addr)
                fwht_pkg::CFG_INDEX_BITS: n_idx_bits = i_cfg_wdata[3:0];
                fwht_pkg::CFG_GENERATION: n_gen      = i_cfg_wdata[7:0];
                default: ;
            endcase
        end

        case (r_state)
            fwht_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_in           = i_cmd;
                    n_addr         = i_cmd.key[fwht_pkg::ADDR_W-1:0] & w_mask;
                    n_way          = '0;
                    n_empty_found  = 1'b0;
                    n_victim_found = 1'b0;
                    case (i_cmd.command)
                        fwht_pkg::CMD_PROBE, fwht_pkg::CMD_PUT: begin
                            n_state = fwht_pkg::S_READ;
                        end
                        fwht_pkg::CMD_CLEAR: begin
                            n_state    = fwht_pkg::S_CLEAR;
                            n_clr_addr = '0;
                            n_clr_cmd  = 1'b1;
                            n_gen      = 8'd0;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '0;
                        end
                    endcase
                end
            end

            fwht_pkg::S_READ: begin
                w_rd_en = 1'b1;
                n_state = fwht_pkg::S_SCAN;
            end

            fwht_pkg::S_SCAN: begin
                if (w_eval.hit) begin
                    n_sel_way = r_way;
                    if (r_in.command == fwht_pkg::CMD_PROBE) begin
                        n_done                  = 1'b1;
                        n_result                = '0;
                        n_result.outcome        = fwht_pkg::OUT_HIT;
                        n_result.hit_depth      = w_cur.depth;
                        n_result.hit_move       = w_cur.move;
                        n_result.hit_value      = w_cur.value;
                        n_result.hit_type       = w_cur.btype;
                        n_result.hit_eval       = w_cur.eval;
                        n_result.hit_generation = w_cur.gen;
                        n_state                 = fwht_pkg::S_IDLE;
                    end else begin
                        n_wr_outcome = fwht_pkg::OUT_UPDATED;
                        n_state      = fwht_pkg::S_WRITE;
                    end
                end else begin
                    // first empty way, first way of lowest score
                    if (w_eval.empty) begin
                        if (!r_empty_found) begin
                            se_found = 1'b1;
                            se_way   = r_way;
                        end
                    end else if (!r_victim_found || (w_eval.score < r_vscore)) begin
                        sv_found = 1'b1;
                        sv_way   = r_way;
                        sv_score = w_eval.score;
                    end
                    n_empty_found  = se_found;
                    n_empty_way    = se_way;
                    n_victim_found = sv_found;
                    n_victim_way   = sv_way;
                    n_vscore       = sv_score;
                    if (r_way == fwht_pkg::WAY_W'(fwht_pkg::WAYS - 1)) begin
                        if (r_in.command == fwht_pkg::CMD_PROBE) begin
                            n_done   = 1'b1;
                            n_result = '0;
                            n_state  = fwht_pkg::S_IDLE;
                        end else if (se_found) begin
                            n_sel_way    = se_way;
                            n_wr_outcome = fwht_pkg::OUT_FILLED;
                            n_state      = fwht_pkg::S_WRITE;
                        end else begin
                            n_sel_way    = sv_way;
                            n_wr_outcome = fwht_pkg::OUT_REPLACED;
                            n_state      = fwht_pkg::S_WRITE;
                        end
                    end else begin
                        n_way = r_way + 1'b1;
                    end
                end
            end

            fwht_pkg::S_WRITE: begin
                w_wr_en             = 1'b1;
                w_wr_row[r_sel_way] = w_new;
                n_done              = 1'b1;
                n_result            = '0;
                n_result.outcome    = r_wr_outcome;
                n_state             = fwht_pkg::S_IDLE;
            end

            fwht_pkg::S_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_row   = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = fwht_pkg::S_IDLE;
                    if (r_clr_cmd) begin
                        n_done           = 1'b1;
                        n_result         = '0;
                        n_result.outcome = fwht_pkg::OUT_CLEARED;
                    end
                end
            end

            default: begin
                n_state = fwht_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= fwht_pkg::S_CLEAR;
            r_way          <= '0;
            r_empty_found  <= 1'b0;
            r_victim_found <= 1'b0;
            r_clr_addr     <= '0;
            r_clr_cmd      <= 1'b0;
            r_idx_bits     <= 4'd10;
            r_gen          <= 8'd0;
            r_done         <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_way          <= n_way;
            r_empty_found  <= n_empty_found;
            r_victim_found <= n_victim_found;
            r_clr_addr     <= n_clr_addr;
            r_clr_cmd      <= n_clr_cmd;
            r_idx_bits     <= n_idx_bits;
            r_gen          <= n_gen;
            r_done         <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_addr       <= n_addr;
        r_sel_way    <= n_sel_way;
        r_wr_outcome <= n_wr_outcome;
        r_empty_way  <= n_empty_way;
        r_victim_way <= n_victim_way;
        r_vscore     <= n_vscore;
        r_result     <= n_result;
    end

    // result shown without a hit, and its hit fields all zero
    assign w_miss_shown  = o_done && (o_result.outcome != fwht_pkg::OUT_HIT);
    assign w_fields_zero = (o_result.hit_depth == 7'd0) && (o_result.hit_move == 16'd0)
                         && (o_result.hit_value == 16'sd0) && (o_result.hit_type == 2'd0)
                         && (o_result.hit_eval == 16'sd0)
                         && (o_result.hit_generation == 8'd0);

    // checks
    `FWHT_ASSERT(a_done_when_idle, i_clk, i_rst_n, o_done |-> !busy, "result strobe while busy")
    `FWHT_ASSERT(a_accept_progress, i_clk, i_rst_n, w_accept |=> busy || o_done, "transaction lost")
    `FWHT_ASSERT(a_miss_zero, i_clk, i_rst_n, w_miss_shown |-> w_fields_zero, "hit fields on a miss")
    `FWHT_ASSERT_ON(a_reset_clears, i_clk, !i_rst_n |=> busy && !o_done, "no clear after reset")

endmodule

@@ tb/four_way_hash_table_checker.sv @@
// checker that predicts and compares every result of the four-way hash table
module four_way_hash_table_checker
    import fwht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_cmd                  i_cmd,
    input  logic                  i_done,
    input  t_result               i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_hits,
    output int                    o_replaced
);

    localparam int SLOTS = (1 << IDX_MAX) * WAYS;

    // one stored way as the predictor keeps it
    typedef struct packed {
        logic [63:0] tag;
        logic [6:0]  depth;
        logic [15:0] move;
        logic [15:0] value;
        logic [1:0]  btype;
        logic [7:0]  gen;
        logic [15:0] eval;
    } t_slot;

    bit         slot_used [SLOTS];
    t_slot      slot_data [SLOTS];
    logic [3:0] model_index_bits = 4'd10;
    logic [7:0] model_generation = 8'd0;

    t_result table_answers_due [$];

    int fail_total    = 0;
    int answers_ready = 0;
    int checked_total = 0;
    int hit_total     = 0;
    int victim_total  = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = answers_ready;
    assign o_checked    = checked_total;
    assign o_hits       = hit_total;
    assign o_replaced   = victim_total;

    // apply one transaction to the predicted table and return its answer
    function automatic t_result access_table(t_cmd c);
        t_result     r;
        int unsigned bits;
        int unsigned base;
        int unsigned e;
        int          empty_way;
        int          victim_way;
        int          victim_score;
        int          score;
        int          age;
        logic [7:0]  gen_gap;
        r = '0;
        r.outcome = OUT_MISS;
        if (c.command == CMD_CLEAR) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            model_generation = 8'd0;
            r.outcome = OUT_CLEARED;
            return r;
        end
        // unused command code answers a bare miss
        if (c.command != CMD_PROBE && c.command != CMD_PUT) return r;

        bits = (model_index_bits > IDX_MAX) ? IDX_MAX : model_index_bits;
        base = int'(c.key & ((64'd1 << bits) - 64'd1)) * WAYS;
        empty_way    = -1;
        victim_way   = -1;
        victim_score = 0;
        for (int w = 0; w < WAYS; w++) begin
            e = base + w;
            if (slot_used[e] && slot_data[e].tag == c.key) begin
                if (c.command == CMD_PROBE) begin
                    r.outcome        = OUT_HIT;
                    r.hit_depth      = slot_data[e].depth;
                    r.hit_move       = slot_data[e].move;
                    r.hit_value      = slot_data[e].value;
                    r.hit_type       = slot_data[e].btype;
                    r.hit_eval       = slot_data[e].eval;
                    r.hit_generation = slot_data[e].gen;
                    return r;
                end
                // in-place update, each part only when given
                if (c.best_move != 16'd0) slot_data[e].move = c.best_move;
                if (c.value_given) begin
                    slot_data[e].depth = c.search_depth;
                    slot_data[e].value = c.score_value;
                    slot_data[e].btype = c.bound_type;
                    slot_data[e].gen   = model_generation;
                end
                if (c.eval_given) slot_data[e].eval = c.static_eval;
                r.outcome = OUT_UPDATED;
                return r;
            end
            if (!slot_used[e]) begin
                if (empty_way < 0) empty_way = w;
            end else begin
                gen_gap = model_generation - slot_data[e].gen;
                age     = int'(gen_gap[2:0]);
                score   = int'(slot_data[e].depth) * 16 - age * 2
                          + ((slot_data[e].move != 16'd0) ? 1 : 0);
                if (victim_way < 0 || score < victim_score) begin
                    victim_way   = w;
                    victim_score = score;
                end
            end
        end
        if (c.command == CMD_PROBE) return r;

        // fill the first empty way, else the lowest-scoring one
        e = base + ((empty_way >= 0) ? empty_way : victim_way);
        slot_used[e]       = 1'b1;
        slot_data[e].tag   = c.key;
        slot_data[e].depth = c.search_depth;
        slot_data[e].move  = c.best_move;
        slot_data[e].value = c.score_value;
        slot_data[e].btype = c.bound_type;
        slot_data[e].gen   = model_generation;
        slot_data[e].eval  = c.static_eval;
        r.outcome = (empty_way >= 0) ? OUT_FILLED : OUT_REPLACED;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_total++;
        end
    endtask

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            model_index_bits = 4'd10;
            model_generation = 8'd0;
            table_answers_due.delete();
        end else begin
            // compare a finished transaction with the oldest prediction
            if (i_done) begin
                if (table_answers_due.size() == 0) begin
                    $display("%0t: result with none expected, got %h", $time, i_result);
                    fail_total++;
                end else begin
                    want = table_answers_due.pop_front();
                    check_field("outcome", want.outcome, i_result.outcome);
                    check_field("hit_depth", want.hit_depth, i_result.hit_depth);
                    check_field("hit_move", want.hit_move, i_result.hit_move);
                    check_field("hit_value", want.hit_value, i_result.hit_value);
                    check_field("hit_type", want.hit_type, i_result.hit_type);
                    check_field("hit_eval", want.hit_eval, i_result.hit_eval);
                    check_field("hit_generation", want.hit_generation,
                                i_result.hit_generation);
                    checked_total++;
                    if (want.outcome == OUT_HIT) hit_total++;
                    if (want.outcome == OUT_REPLACED) victim_total++;
                end
            end
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_INDEX_BITS) model_index_bits = i_cfg_wdata[3:0];
                else if (i_cfg_addr == CFG_GENERATION) model_generation = i_cfg_wdata[7:0];
            end
            // accepted transaction
            if (i_start && !i_busy) table_answers_due.push_back(access_table(i_cmd));
        end
        answers_ready = table_answers_due.size();
    end

endmodule

@@ tb/tb_four_way_hash_table_depth_age_replace.sv @@
// stimulus and verdict for the four-way hash table with depth/age replacement
module tb_four_way_hash_table_depth_age_replace;
    import fwht_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int KEY_POOL = 16;
    localparam int PHASES   = 8;
    localparam int PHASE_ITEMS = 150;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cmd_start = 1'b0;
    t_cmd                  cmd_bus   = '0;
    logic                  busy;
    logic                  done;
    t_result               result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int fail_count;
    int answers_pending;
    int results_checked;
    int probe_hits;
    int victims_replaced;
    int items_sent = 0;

    logic [63:0] key_pool [KEY_POOL];

    always #1 clk = ~clk;

    four_way_hash_table_depth_age_replace i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (cmd_start),
        .i_cmd      (cmd_bus),
        .busy       (busy),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    four_way_hash_table_checker table_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (cmd_start),
        .i_busy      (busy),
        .i_cmd       (cmd_bus),
        .i_done      (done),
        .i_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (answers_pending),
        .o_checked   (results_checked),
        .o_hits      (probe_hits),
        .o_replaced  (victims_replaced)
    );

    function automatic t_cmd table_request(logic [1:0] cmd, logic [63:0] key,
                                           logic [6:0] depth, logic [15:0] move,
                                           logic [15:0] value, logic vgiven,
                                           logic [1:0] btype, logic [15:0] eval,
                                           logic egiven);
        t_cmd c;
        c.command      = cmd;
        c.key          = key;
        c.search_depth = depth;
        c.best_move    = move;
        c.score_value  = value;
        c.value_given  = vgiven;
        c.bound_type   = btype;
        c.static_eval  = eval;
        c.eval_given   = egiven;
        return c;
    endfunction

    // present one transaction and return at the falling edge after it was taken
    task automatic issue(t_cmd c);
        cmd_bus   <= c;
        cmd_start <= 1'b1;
        while (busy !== 1'b0) @(negedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // wait until the block is idle and every answer is back
    task automatic wait_idle();
        while (busy !== 1'b0 || answers_pending != 0) @(negedge clk);
    endtask

    // write both registers, upper data bits of index_bits randomized
    task automatic configure(logic [3:0] idx, logic [7:0] gen);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_INDEX_BITS;
        cfg_wdata <= {4'($urandom_range(0, 15)), idx};
        @(negedge clk);
        cfg_addr  <= CFG_GENERATION;
        cfg_wdata <= gen;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random transactions in bursts, mostly on a small pool of colliding keys
    task automatic run_random(int count);
        int          sent;
        int          burst;
        int          gap;
        int          roll;
        int          slot;
        logic [1:0]  cmd;
        logic [63:0] key;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if (sent < count) begin
                    roll = $urandom_range(0, 99);
                    cmd = (roll < 42) ? CMD_PROBE : (roll < 96) ? CMD_PUT :
                          (roll < 98) ? CMD_UNUSED : CMD_CLEAR;
                    slot = $urandom_range(0, KEY_POOL - 1);
                    if ($urandom_range(0, 99) < 12) begin
                        key = {$urandom, $urandom};
                        // fresh puts sometimes join the pool
                        if (cmd == CMD_PUT && $urandom_range(0, 1) == 1) key_pool[slot] = key;
                    end else begin
                        key = key_pool[slot];
                    end
                    issue(table_request(cmd, key, 7'($urandom_range(0, 127)),
                        ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                        16'($urandom), ($urandom_range(0, 3) != 0),
                        2'($urandom_range(0, 3)), 16'($urandom),
                        ($urandom_range(0, 3) != 0)));
                    sent++;
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                cmd_start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        cmd_start <= 1'b0;
    endtask

    // overall time limit
    initial begin
        #1000000;
        $display("%0t: timeout, %0d answers still outstanding", $time, answers_pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [63:0] ones;
        logic [63:0] k5 [5];
        logic [3:0]  idx;
        logic [7:0]  gen;
        ones = '1;

        // keys spread over three clusters, upper bits random
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = {$urandom, $urandom};
            case (i % 3)
                0:       key_pool[i][9:0] = 10'h000;
                1:       key_pool[i][9:0] = 10'h2a5;
                default: key_pool[i][9:0] = 10'h3ff;
            endcase
        end
        for (int i = 0; i < 5; i++) begin
            k5[i] = {$urandom, $urandom};
            k5[i][9:0] = 10'd5;
        end

        // reset, then let the power-up clearing pass finish
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        wait_idle();
        configure(4'd10, 8'd9);

        // directed: key zero, update flags, field extremes
        issue(table_request(CMD_PROBE, 64'd0, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        issue(table_request(CMD_PUT, 64'd0, 7'd0, 16'd0, 16'd0, 1'b1, 2'd0, 16'd0, 1'b1));
        issue(table_request(CMD_PROBE, 64'd0, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        issue(table_request(CMD_PUT, 64'd0, 7'd127, 16'd0, 16'h7fff, 1'b0, 2'd3,
                            16'h7fff, 1'b0));
        issue(table_request(CMD_PROBE, 64'd0, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        issue(table_request(CMD_PUT, 64'd0, 7'd127, 16'hffff, 16'h8000, 1'b1, 2'd3,
                            16'h7fff, 1'b1));
        issue(table_request(CMD_PROBE, 64'd0, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        issue(table_request(CMD_PUT, 64'd0, 7'd5, 16'd0, 16'h7fff, 1'b1, 2'd1,
                            16'h8000, 1'b0));
        issue(table_request(CMD_PROBE, 64'd0, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        // a fill writes every field whatever the flags say
        issue(table_request(CMD_PUT, ones, 7'd1, 16'h1234, 16'hffff, 1'b0, 2'd2,
                            16'hfffe, 1'b0));
        issue(table_request(CMD_PROBE, ones, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        // fill one cluster, then force a victim: lowest score, move-less way loses
        issue(table_request(CMD_PUT, k5[0], 7'd10, 16'd7, 16'd1, 1'b1, 2'd0, 16'd1, 1'b1));
        issue(table_request(CMD_PUT, k5[1], 7'd3, 16'd9, 16'd2, 1'b1, 2'd1, 16'd2, 1'b1));
        issue(table_request(CMD_PUT, k5[2], 7'd3, 16'd0, 16'd3, 1'b1, 2'd2, 16'd3, 1'b1));
        issue(table_request(CMD_PUT, k5[3], 7'd20, 16'd4, 16'd4, 1'b1, 2'd3, 16'd4, 1'b1));
        issue(table_request(CMD_PUT, k5[4], 7'd2, 16'd5, 16'd5, 1'b1, 2'd0, 16'd5, 1'b1));
        issue(table_request(CMD_PROBE, k5[2], 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        issue(table_request(CMD_PROBE, k5[3], 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        issue(table_request(CMD_PROBE, k5[4], 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        // unused command code changes nothing
        issue(table_request(CMD_UNUSED, 64'd0, 7'd127, 16'hffff, 16'hffff, 1'b1, 2'd3,
                            16'hffff, 1'b1));
        issue(table_request(CMD_PROBE, 64'd0, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        // clear empties everything and zeroes the generation
        issue(table_request(CMD_CLEAR, ones, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        issue(table_request(CMD_PROBE, 64'd0, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        issue(table_request(CMD_PUT, ones, 7'd64, 16'h8000, 16'h0100, 1'b1, 2'd1,
                            16'h0010, 1'b1));
        issue(table_request(CMD_PROBE, ones, 7'd0, 16'd0, 16'd0, 1'b0, 2'd0, 16'd0, 1'b0));
        cmd_start <= 1'b0;

        // random phases, each configuring its own index_bits and generation
        for (int p = 0; p < PHASES; p++) begin
            @(negedge clk);
            wait_idle();
            case (p)
                0:       begin idx = 4'd10; gen = 8'd1;   end
                1:       begin idx = 4'd0;  gen = 8'd255; end
                2:       begin idx = 4'd15; gen = 8'd0;   end
                3:       begin idx = 4'd3;  gen = 8'($urandom); end
                4:       begin idx = 4'd1;  gen = gen + 8'd1; end
                5:       begin idx = 4'd11; gen = 8'($urandom); end
                6:       begin idx = 4'd6;  gen = 8'd250; end
                default: begin idx = 4'd2;  gen = gen + 8'd3; end
            endcase
            configure(idx, gen);
            run_random(PHASE_ITEMS);
        end

        // drain and let any stray result show up
        @(negedge clk);
        wait_idle();
        repeat (20) @(negedge clk);

        $display("run: %0d transactions over %0d table settings, %0d answers checked",
                 items_sent, PHASES + 1, results_checked);
        $display("run: %0d probe hits, %0d victims replaced", probe_hits, victims_replaced);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/fwht_pkg.sv
hw/rtl/fwht_ram.sv
hw/rtl/fwht_way_unit.sv
hw/rtl/four_way_hash_table_depth_age_replace.sv
tb/four_way_hash_table_checker.sv
tb/tb_four_way_hash_table_depth_age_replace.sv
